// ===== hdl/fsc_pkg.sv =====
// ----------------------------------------------------------------------------
// fsc_pkg
// Shared types, character codes and helper functions for the fixed-form
// statement cruncher.
// ----------------------------------------------------------------------------
package fsc_pkg;

   // width of the hollerith count and of the digit-run value
   localparam int COUNT_BITS = 12;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   // marker for "nothing emitted yet on this card" / "field start"
   localparam logic [7:0] NOTHING = 8'd128;

   // character codes
   localparam logic [6:0] CH_BANG    = 7'h21;  // !
   localparam logic [6:0] CH_DQUOTE  = 7'h22;  // "
   localparam logic [6:0] CH_APOS    = 7'h27;  // '
   localparam logic [6:0] CH_LPAREN  = 7'h28;  // (
   localparam logic [6:0] CH_STAR    = 7'h2A;  // *
   localparam logic [6:0] CH_COMMA   = 7'h2C;  // ,
   localparam logic [6:0] CH_DOT     = 7'h2E;  // .
   localparam logic [6:0] CH_SLASH   = 7'h2F;  // /
   localparam logic [6:0] CH_EQUAL   = 7'h3D;  // =
   localparam logic [6:0] CH_UPPER_D = 7'h44;  // D
   localparam logic [6:0] CH_UPPER_H = 7'h48;  // H
   localparam logic [6:0] CH_LOWER_D = 7'h64;  // d
   localparam logic [6:0] CH_LOWER_H = 7'h68;  // h
   localparam logic [6:0] CH_LOWER_X = 7'h78;  // x
   localparam logic [6:0] CH_SPACE   = 7'h20;
   localparam logic [6:0] CH_TAB     = 7'h09;
   localparam logic [6:0] CH_NEWLINE = 7'h0A;

   // header columns of a comment run
   localparam logic [7:0] COL_HDR_NL = 8'hFF;  // -1
   localparam logic [7:0] COL_HDR_X  = 8'h00;

   // literal kinds
   localparam logic [1:0] SQ_NONE = 2'd0;
   localparam logic [1:0] SQ_APOS = 2'd1;
   localparam logic [1:0] SQ_DQ   = 2'd2;

   // output routes
   localparam logic ROUTE_STMT    = 1'b0;
   localparam logic ROUTE_COMMENT = 1'b1;

   // one result beat
   typedef struct packed {
      logic       route;
      logic [6:0] ch;
      logic [7:0] col;
   } res_type;

   function automatic logic is_digit(input logic [6:0] c);
      return (c >= 7'h30) && (c <= 7'h39);
   endfunction

   function automatic logic is_blank(input logic [6:0] c);
      return (c == CH_SPACE) || (c == CH_TAB);
   endfunction

   function automatic logic [6:0] to_lower(input logic [6:0] c);
      return ((c >= 7'h41) && (c <= 7'h5A)) ? (c | 7'h20) : c;
   endfunction

endpackage

// ===== hdl/fixed_form_statement_cruncher.sv =====
// ----------------------------------------------------------------------------
// fixed_form_statement_cruncher
// Crunches the statement field of fixed-form cards one character per beat.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one statement-field character per beat with its column;
//     tlast marks the last character of a card, tuser carries the card
//     start, initial-line and label-bang flags.
//   rsp channel: zero to three result beats per request beat; tuser is the
//     route (statement or comment stream), tlast marks the last result of
//     one request. Blanks outside literals give no beat, a '!' comment
//     opener gives three (newline, 'x', '!').
//   A request beat lands in the input register and is processed from there
//     into the result register, from which its first result is taken.
//   Throughput: one request per cycle while each gives at most one result and
//     the receiver is ready; a request with more results holds the result
//     register until all are taken, since it drains one beat per cycle.
//   Reset clears all literal, hollerith and comment state and both
//     registers' valid flags. When the receiver stalls the result register
//     holds, the input register still takes one more beat, then req_tready
//     drops until the pending results are drained.
// ----------------------------------------------------------------------------
module fixed_form_statement_cruncher
   import fsc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // ch[6:0], col[13:7], zero[15:14]
   input  logic [2:0]  req_tuser,   // card_start[0], initial_line[1], label_bang[2]
   input  logic        req_tlast,   // card_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // out_char[6:0], out_col[14:7], zero[15]
   output logic        rsp_tuser,   // route
   output logic        rsp_tlast    // last_of_run
);

   // input register
   logic                  in_valid_ff;
   logic [6:0]            in_ch_ff;
   logic [6:0]            in_col_ff;
   logic                  in_cs_ff;
   logic                  in_ce_ff;
   logic                  in_il_ff;
   logic                  in_lb_ff;

   // cruncher state
   logic [1:0]            sq_ff,   sq_in;
   logic                  qp_ff,   qp_in;
   logic [COUNT_BITS-1:0] holl_ff, holl_in;
   logic [6:0]            fc_ff,   fc_in;
   logic                  fcs_ff,  fcs_in;
   logic [COUNT_BITS-1:0] drv_ff,  drv_in;
   logic                  dra_ff,  dra_in;
   logic [7:0]            cbr_ff,  cbr_in;
   logic [7:0]            loc_ff,  loc_in;
   logic                  cm_ff,   cm_in;

   // result register
   res_type               res_ff  [3];
   res_type               res_in  [3];
   logic [1:0]            rem_ff;
   logic [1:0]            nres_in;

   logic                  advance;
   logic                  pop;
   logic                  holl_step;

   // handshake
   assign pop        = (rem_ff != 2'd0) && rsp_tready;
   assign advance    = in_valid_ff && ((rem_ff == 2'd0) || ((rem_ff == 2'd1) && rsp_tready));
   assign req_tready = !in_valid_ff || advance;

   assign rsp_tvalid = (rem_ff != 2'd0);
   assign rsp_tdata  = {1'b0, res_ff[0].col, res_ff[0].ch};
   assign rsp_tuser  = res_ff[0].route;
   assign rsp_tlast  = (rem_ff == 2'd1);

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
      if (req_tready && req_tvalid) begin
         in_ch_ff  <= req_tdata[6:0];
         in_col_ff <= req_tdata[13:7];
         in_cs_ff  <= req_tuser[0];
         in_il_ff  <= req_tuser[1];
         in_lb_ff  <= req_tuser[2];
         in_ce_ff  <= req_tlast;
      end
   end

   // per-character crunch: next state and result beats
   always_comb begin
      logic [6:0]            qc;
      logic [7:0]            loc1;
      logic [7:0]            cbr1;
      logic                  dra1;
      logic [COUNT_BITS-1:0] drv1;
      logic                  cm1;
      logic                  clr_lit;
      logic                  live;
      logic                  se;
      logic [6:0]            sc;
      logic                  may_count;
      logic [COUNT_BITS+3:0] v;
      logic [7:0]            col8;

      col8 = {1'b0, in_col_ff};
      qc   = (sq_ff == SQ_APOS) ? CH_APOS : CH_DQUOTE;

      // card start clears per-card state
      clr_lit = in_cs_ff && (qp_ff || in_il_ff);
      loc1    = in_cs_ff ? NOTHING : loc_ff;
      cbr1    = in_cs_ff ? NOTHING : cbr_ff;
      dra1    = in_cs_ff ? 1'b0 : dra_ff;
      drv1    = in_cs_ff ? '0 : drv_ff;
      cm1     = in_cs_ff ? 1'b0 : cm_ff;
      sq_in   = clr_lit ? SQ_NONE : sq_ff;
      qp_in   = clr_lit ? 1'b0 : qp_ff;
      fcs_in  = (in_cs_ff && in_il_ff) ? 1'b0 : fcs_ff;
      fc_in   = fc_ff;

      // first non-blank of the statement
      if (in_il_ff && !fcs_in && !is_blank(in_ch_ff)) begin
         fc_in  = in_ch_ff;
         fcs_in = 1'b1;
      end

      holl_in   = holl_ff;
      holl_step = 1'b0;
      cm_in     = cm1;
      se        = 1'b0;
      sc        = in_ch_ff;
      nres_in   = 2'd0;
      live      = 1'b1;
      for (int i = 0; i < 3; i++) begin
         res_in[i] = '{route: ROUTE_STMT, ch: in_ch_ff, col: col8};
      end

      may_count = (cbr1 == NOTHING) || (cbr1 == {1'b0, CH_SLASH}) ||
                  (cbr1 == {1'b0, CH_LPAREN}) || (cbr1 == {1'b0, CH_COMMA}) ||
                  (cbr1 == {1'b0, CH_EQUAL}) || (cbr1 == {1'b0, CH_DOT}) ||
                  ((cbr1 == {1'b0, CH_STAR}) &&
                   ((fc_in == CH_LOWER_D) || (fc_in == CH_UPPER_D)));

      // main dispatch
      if (in_lb_ff) begin
         nres_in = 2'd1;
      end else if (cm1) begin
         nres_in         = 2'd1;
         res_in[0].route = ROUTE_COMMENT;
      end else if (holl_ff != '0) begin
         se        = 1'b1;
         holl_in   = holl_ff - 1'b1;
         holl_step = 1'b1;
      end else begin
         // closing-quote candidate from the previous beat
         if (qp_in) begin
            qp_in = 1'b0;
            if ((sq_in != SQ_NONE) && (in_ch_ff == qc)) begin
               se   = 1'b1;
               live = 1'b0;
            end else begin
               sq_in = SQ_NONE;
            end
         end
         if (live) begin
            if (sq_in != SQ_NONE) begin
               se = 1'b1;
               if (in_ch_ff == qc) begin
                  if (in_ce_ff) begin
                     sq_in = SQ_NONE;
                  end else begin
                     qp_in = 1'b1;
                  end
               end
            end else if (is_blank(in_ch_ff)) begin
               se = 1'b0;
            end else if (in_ch_ff == CH_BANG) begin
               nres_in   = 2'd3;
               res_in[0] = '{route: ROUTE_COMMENT, ch: CH_NEWLINE, col: COL_HDR_NL};
               res_in[1] = '{route: ROUTE_COMMENT, ch: CH_LOWER_X, col: COL_HDR_X};
               res_in[2] = '{route: ROUTE_COMMENT, ch: in_ch_ff,   col: col8};
               cm_in     = 1'b1;
            end else if ((in_ch_ff == CH_APOS) || (in_ch_ff == CH_DQUOTE)) begin
               sq_in = (in_ch_ff == CH_APOS) ? SQ_APOS : SQ_DQ;
               se    = 1'b1;
            end else if ((in_ch_ff == CH_LOWER_H) || (in_ch_ff == CH_UPPER_H)) begin
               se = 1'b1;
               sc = CH_LOWER_H;
               if (dra1 && may_count) begin
                  holl_in = drv1;
               end
            end else begin
               se = 1'b1;
               sc = to_lower(in_ch_ff);
            end
         end
      end

      // statement emit and digit-run tracking
      loc_in = loc1;
      cbr_in = cbr1;
      dra_in = dra1;
      drv_in = drv1;
      v      = ({4'b0, drv1} << 3) + ({4'b0, drv1} << 1) +
               {{COUNT_BITS{1'b0}}, sc[3:0]};
      if (se) begin
         nres_in      = 2'd1;
         res_in[0].ch = sc;
         loc_in       = {1'b0, sc};
         if (is_digit(sc)) begin
            if (!dra1) begin
               cbr_in = loc1;
               drv_in = {{(COUNT_BITS-4){1'b0}}, sc[3:0]};
               dra_in = 1'b1;
            end else begin
               drv_in = (v > {4'b0, COUNT_MAX}) ? COUNT_MAX : v[COUNT_BITS-1:0];
            end
         end else begin
            dra_in = 1'b0;
         end
      end

      if (in_ce_ff) begin
         cm_in = 1'b0;
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sq_ff   <= SQ_NONE;
         qp_ff   <= 1'b0;
         holl_ff <= '0;
         fc_ff   <= '0;
         fcs_ff  <= 1'b0;
         drv_ff  <= '0;
         dra_ff  <= 1'b0;
         cbr_ff  <= NOTHING;
         loc_ff  <= NOTHING;
         cm_ff   <= 1'b0;
      end else if (advance) begin
         sq_ff   <= sq_in;
         qp_ff   <= qp_in;
         holl_ff <= holl_in;
         fc_ff   <= fc_in;
         fcs_ff  <= fcs_in;
         drv_ff  <= drv_in;
         dra_ff  <= dra_in;
         cbr_ff  <= cbr_in;
         loc_ff  <= loc_in;
         cm_ff   <= cm_in;
      end
   end

   // result register: load on advance, shift down on each taken beat
   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= 2'd0;
      end else if (advance) begin
         rem_ff <= nres_in;
      end else if (pop) begin
         rem_ff <= rem_ff - 2'd1;
      end
      if (advance) begin
         res_ff[0] <= res_in[0];
         res_ff[1] <= res_in[1];
         res_ff[2] <= res_in[2];
      end else if (pop) begin
         res_ff[0] <= res_ff[1];
         res_ff[1] <= res_ff[2];
      end
   end

   // checks
   a_adv_drained: assert property (@(posedge clock) disable iff (reset)
      advance |-> ((rem_ff == 2'd0) || ((rem_ff == 2'd1) && rsp_tready)))
      else $error("new item loaded over pending results");

   a_hdr_first: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (res_ff[0].col == COL_HDR_NL)) |-> (rem_ff == 2'd3))
      else $error("comment header newline not at head of a three-beat run");

   a_qp_in_lit: assert property (@(posedge clock) disable iff (reset)
      qp_ff |-> (sq_ff != SQ_NONE))
      else $error("quote pending outside a literal");

   a_holl_down: assert property (@(posedge clock) disable iff (reset)
      (advance && holl_step) |=> (holl_ff == $past(holl_ff) - 1'b1))
      else $error("hollerith count did not step down");

   a_cm_no_qp: assert property (@(posedge clock) disable iff (reset)
      cm_ff |-> !qp_ff)
      else $error("comment mode with a quote pending");

endmodule

// ===== tb/fsc_result_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fsc_result_checker
// Watches both streams of the fixed-form statement cruncher. Each accepted
// request beat runs through a local model of the cruncher (literals, hollerith
// counts, comment routing, label-bang pass-through), and the result beats it
// implies are queued. Each accepted result beat is compared field by field
// against the oldest queued beat.
// ----------------------------------------------------------------------------
module fsc_result_checker
   import fsc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [15:0]           req_tdata,     // ch[6:0], col[13:7], zero[15:14]
   input  logic [2:0]            req_tuser,     // card_start[0], initial_line[1], label_bang[2]
   input  logic                  req_tlast,     // card_end
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [15:0]           rsp_tdata,     // out_char[6:0], out_col[14:7], zero[15]
   input  logic                  rsp_tuser,     // route
   input  logic                  rsp_tlast,     // last_of_run
   output int unsigned           fail_count,
   output int unsigned           pending,
   output int unsigned           beats_checked,
   output int unsigned           comment_beats,
   output logic [COUNT_BITS-1:0] verbatim_left
);

   typedef struct packed {
      logic       route;
      logic [6:0] ch;
      logic [7:0] col;
      logic       last;
   } crunched_beat_type;

   crunched_beat_type expected_q[$];
   crunched_beat_type burst[3];
   int                burst_n;
   int unsigned       mismatches = 0;
   int unsigned       checked = 0;
   int unsigned       comments = 0;

   // crunching state
   logic [1:0]            lit_kind = SQ_NONE;
   logic                  close_pending = 1'b0;
   logic [COUNT_BITS-1:0] holl_left = '0;
   logic [6:0]            stmt_first = '0;
   logic                  stmt_first_seen = 1'b0;
   logic [COUNT_BITS-1:0] run_value = '0;
   logic                  run_active = 1'b0;
   logic [7:0]            run_prefix = NOTHING;
   logic [7:0]            prev_emitted = NOTHING;
   logic                  in_comment = 1'b0;

   assign verbatim_left = holl_left;

   // queue one beat of the current request, at most three
   task automatic emit_beat(input logic route, input logic [6:0] c, input logic [7:0] col);
      if (burst_n < 3) begin
         burst[burst_n].route = route;
         burst[burst_n].ch    = c;
         burst[burst_n].col   = col;
         burst[burst_n].last  = 1'b0;
         burst_n++;
      end
   endtask

   // statement-stream beat, tracking the digit run that may form a count
   task automatic emit_stmt(input logic [6:0] c, input logic [6:0] col);
      int grown;
      emit_beat(ROUTE_STMT, c, {1'b0, col});
      if (c >= "0" && c <= "9") begin
         if (!run_active) begin
            run_prefix = prev_emitted;
            run_value  = COUNT_BITS'(int'(c) - int'("0"));
            run_active = 1'b1;
         end else begin
            grown     = int'(run_value) * 10 + int'(c) - int'("0");
            run_value = (grown > int'(COUNT_MAX)) ? COUNT_MAX : grown[COUNT_BITS-1:0];
         end
      end else begin
         run_active = 1'b0;
      end
      prev_emitted = {1'b0, c};
   endtask

   // a count before h is only a hollerith count after these characters
   function automatic logic count_allowed(input logic [7:0] b);
      if (b == NOTHING || b == {1'b0, CH_SLASH} || b == {1'b0, CH_LPAREN} ||
          b == {1'b0, CH_COMMA} || b == {1'b0, CH_EQUAL} || b == {1'b0, CH_DOT})
         return 1'b1;
      return (b == {1'b0, CH_STAR}) && (stmt_first == CH_LOWER_D || stmt_first == CH_UPPER_D);
   endfunction

   // predict the result beats of one request beat
   task automatic crunch_char(input logic [6:0] c, input logic [6:0] col, input logic cs,
                              input logic ce, input logic il, input logic lb);
      logic [6:0]            qc;
      logic                  live;
      logic                  holl;
      logic [COUNT_BITS-1:0] cnt;
      qc      = (lit_kind == SQ_APOS) ? CH_APOS : CH_DQUOTE;
      burst_n = 0;

      // card start clears per-card tracking
      if (cs) begin
         prev_emitted = NOTHING;
         run_prefix   = NOTHING;
         run_active   = 1'b0;
         run_value    = '0;
         in_comment   = 1'b0;
         if (close_pending) begin
            lit_kind      = SQ_NONE;
            close_pending = 1'b0;
         end
         if (il) begin
            lit_kind        = SQ_NONE;
            close_pending   = 1'b0;
            stmt_first_seen = 1'b0;
         end
      end
      if (il && !stmt_first_seen && c != CH_SPACE && c != CH_TAB) begin
         stmt_first      = c;
         stmt_first_seen = 1'b1;
      end

      if (lb) begin
         emit_beat(ROUTE_STMT, c, {1'b0, col});
      end else if (in_comment) begin
         emit_beat(ROUTE_COMMENT, c, {1'b0, col});
      end else if (holl_left != 0) begin
         emit_stmt(c, col);
         holl_left = holl_left - 1'b1;
      end else begin
         live = 1'b1;
         // a quote seen last beat either doubles or closes the literal
         if (close_pending) begin
            close_pending = 1'b0;
            if (lit_kind != SQ_NONE && c == qc) begin
               emit_stmt(c, col);
               live = 1'b0;
            end else begin
               lit_kind = SQ_NONE;
            end
         end
         if (live) begin
            if (lit_kind != SQ_NONE) begin
               emit_stmt(c, col);
               if (c == qc) begin
                  if (ce) lit_kind = SQ_NONE;
                  else close_pending = 1'b1;
               end
            end else if (c == CH_SPACE || c == CH_TAB) begin
               // blanks vanish outside literals
            end else if (c == CH_BANG) begin
               emit_beat(ROUTE_COMMENT, CH_NEWLINE, COL_HDR_NL);
               emit_beat(ROUTE_COMMENT, CH_LOWER_X, COL_HDR_X);
               emit_beat(ROUTE_COMMENT, c, {1'b0, col});
               in_comment = 1'b1;
            end else if (c == CH_APOS || c == CH_DQUOTE) begin
               lit_kind = (c == CH_APOS) ? SQ_APOS : SQ_DQ;
               emit_stmt(c, col);
            end else if (c == CH_LOWER_H || c == CH_UPPER_H) begin
               holl = run_active && count_allowed(run_prefix);
               cnt  = run_value;
               emit_stmt(CH_LOWER_H, col);
               if (holl) holl_left = cnt;
            end else begin
               emit_stmt((c >= "A" && c <= "Z") ? c + 7'h20 : c, col);
            end
         end
      end

      if (ce) in_comment = 1'b0;
      for (int i = 0; i < burst_n; i++) begin
         if (i == burst_n - 1) burst[i].last = 1'b1;
         expected_q.push_back(burst[i]);
      end
   endtask

   task automatic check_field(input string what, input int want, input int got);
      if (want != got) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      end
   endtask

   // predict on request beats, compare on result beats
   always @(posedge clock) begin
      crunched_beat_type want;
      if (reset) begin
         lit_kind        = SQ_NONE;
         close_pending   = 1'b0;
         holl_left       = '0;
         stmt_first      = '0;
         stmt_first_seen = 1'b0;
         run_value       = '0;
         run_active      = 1'b0;
         run_prefix      = NOTHING;
         prev_emitted    = NOTHING;
         in_comment      = 1'b0;
         expected_q.delete();
      end else begin
         if (req_tvalid && req_tready)
            crunch_char(req_tdata[6:0], req_tdata[13:7], req_tuser[0], req_tlast,
                        req_tuser[1], req_tuser[2]);
         if (rsp_tvalid && rsp_tready) begin
            checked++;
            if (rsp_tuser == ROUTE_COMMENT) comments++;
            if (expected_q.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected result beat, expected none, %s %0b %0d %0d %0b",
                        $time, "actual route/char/col/last", rsp_tuser, rsp_tdata[6:0],
                        $signed(rsp_tdata[14:7]), rsp_tlast);
            end else begin
               want = expected_q.pop_front();
               check_field("route", int'(want.route), int'(rsp_tuser));
               check_field("out_char", int'(want.ch), int'(rsp_tdata[6:0]));
               check_field("out_col", int'($signed(want.col)), int'($signed(rsp_tdata[14:7])));
               check_field("last_of_run", int'(want.last), int'(rsp_tlast));
            end
         end
      end
      fail_count    <= mismatches;
      pending       <= expected_q.size();
      beats_checked <= checked;
      comment_beats <= comments;
   end

endmodule

// ===== tb/fixed_form_statement_cruncher_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fixed_form_statement_cruncher_tb
// Feeds the cruncher fixed-form cards: a short directed set (hollerith across
// cards, doubled and end-of-card quotes, unterminated cards, comments,
// label-bang cards, field extremes), then random statements built from
// Fortran-like tokens with noise beats, under several idle/stall phases, and
// finally a saturated hollerith count. Checking is done by fsc_result_checker.
// ----------------------------------------------------------------------------
module fixed_form_statement_cruncher_tb
   import fsc_pkg::*;
();

   localparam int RANDOM_ITEMS = 240;
   localparam int STALL_LIMIT  = 3000;
   localparam int DRAIN_CYCLES = 16;
   localparam int FIRST_COL    = 7;
   localparam int FILLER_CARD  = 20;
   localparam int SAT_FILLER   = 25;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;    // ch[6:0], col[13:7], zero[15:14]
   logic [2:0]  req_tuser = '0;    // card_start[0], initial_line[1], label_bang[2]
   logic        req_tlast = 1'b0;  // card_end
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;         // out_char[6:0], out_col[14:7], zero[15]
   logic        rsp_tuser;         // route
   logic        rsp_tlast;         // last_of_run

   int unsigned           fail_count;
   int unsigned           pending;
   int unsigned           beats_checked;
   int unsigned           comment_beats;
   logic [COUNT_BITS-1:0] verbatim_left;

   int send_gap_pct   = 0;
   int sink_stall_pct = 0;
   int chars_sent     = 0;
   int counted        = 0;
   int cards_sent     = 0;
   int idle_cycles    = 0;

   logic [6:0] text_q[$];

   fixed_form_statement_cruncher u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   fsc_result_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .req_tlast     (req_tlast),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .rsp_tlast     (rsp_tlast),
      .fail_count    (fail_count),
      .pending       (pending),
      .beats_checked (beats_checked),
      .comment_beats (comment_beats),
      .verbatim_left (verbatim_left)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // result-side back pressure
   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= ($urandom_range(99) >= sink_stall_pct);
   end

   // watchdog on cycles with no beat accepted on either side
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == STALL_LIMIT) begin
         $display("%0t: no beat accepted for %0d cycles", $time, STALL_LIMIT);
         $display("CHECKS FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // one request beat, with random sender gaps before it
   task automatic push_char(input logic [6:0] c, input logic [6:0] col, input logic cs,
                            input logic ce, input logic il, input logic lb);
      while ($urandom_range(99) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, col, c};
      req_tuser  <= {lb, il, cs};
      req_tlast  <= ce;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      chars_sent++;
      if (c != CH_SPACE && c != CH_TAB) counted++;
   endtask

   task automatic add_text(input string s);
      for (int i = 0; i < s.len(); i++) text_q.push_back(7'(s[i]));
   endtask

   // send up to len characters of the text buffer as one card
   task automatic send_card(input int len, input logic il, input logic lb, input logic with_end);
      int n;
      n = (len < text_q.size()) ? len : text_q.size();
      for (int i = 0; i < n; i++)
         push_char(text_q.pop_front(), 7'(FIRST_COL + i), i == 0, with_end && (i == n - 1),
                   il, lb);
      cards_sent++;
   endtask

   // hold the sender until every predicted beat has arrived
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   // random printable cards, complete, initial or continuation
   task automatic send_filler(input int count);
      int k;
      while (count > 0) begin
         k = (count < FILLER_CARD) ? count : FILLER_CARD;
         repeat (k) text_q.push_back(7'($urandom_range(32, 126)));
         send_card(k, 1'($urandom_range(1)), 1'b0, 1'b1);
         count -= k;
      end
   endtask

   // one fortran-like token into the text buffer
   task automatic add_token(input logic is_data);
      int    n;
      string punct;
      logic [6:0] q;
      punct = "/(,=.";
      case ($urandom_range(9))
         0, 1: begin
            repeat ($urandom_range(1, 4))
               text_q.push_back(7'($urandom_range(1) ? $urandom_range("a", "z")
                                                      : $urandom_range("A", "Z")));
         end
         2: repeat ($urandom_range(1, 2)) text_q.push_back($urandom_range(1) ? CH_SPACE : CH_TAB);
         3: begin
            punct = "/(,=.*+)-";
            text_q.push_back(7'(punct[$urandom_range(8)]));
         end
         4: repeat ($urandom_range(3) == 0 ? 2 : 1) text_q.push_back(7'($urandom_range("0", "9")));
         5, 6: begin
            // hollerith constant, possibly running past the card
            if (is_data && $urandom_range(1)) text_q.push_back(CH_STAR);
            else text_q.push_back(7'(punct[$urandom_range(4)]));
            n = $urandom_range(1, 5);
            text_q.push_back(7'("0" + n));
            text_q.push_back($urandom_range(1) ? CH_LOWER_H : CH_UPPER_H);
            repeat (n) text_q.push_back(7'($urandom_range(32, 126)));
         end
         7: begin
            q = $urandom_range(1) ? CH_APOS : CH_DQUOTE;
            text_q.push_back(q);
            repeat ($urandom_range(4)) begin
               if ($urandom_range(4) == 0) begin
                  text_q.push_back(q);
                  text_q.push_back(q);
               end else begin
                  text_q.push_back(7'($urandom_range(32, 126)));
               end
            end
            if ($urandom_range(5) != 0) text_q.push_back(q);
         end
         8: begin
            text_q.push_back(CH_BANG);
            repeat ($urandom_range(4)) text_q.push_back(7'($urandom_range(32, 126)));
         end
         default: text_q.push_back(7'($urandom_range(127)));
      endcase
   endtask

   // stimulus and verdict
   initial begin
      int   phase;
      int   base;
      logic is_data;
      logic first;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // hollerith after '*' in a data statement, running into the continuation
      add_text("D*2h");
      send_card(99, 1'b1, 1'b0, 1'b1);
      add_text("A B");
      send_card(99, 1'b0, 1'b0, 1'b1);
      // doubled quote, then a quote closing at card end
      add_text("'A'''");
      send_card(99, 1'b1, 1'b0, 1'b1);
      // literal opened at card end stays open
      add_text("\"");
      send_card(99, 1'b1, 1'b0, 1'b1);
      // card without an end and a pending quote, closed by the next card start
      add_text("B\"");
      send_card(99, 1'b0, 1'b0, 1'b0);
      add_text("\t!Q");
      send_card(99, 1'b0, 1'b0, 1'b1);
      // label-bang card with field extremes
      push_char(7'h00, 7'd0, 1'b1, 1'b0, 1'b1, 1'b1);
      push_char(7'h7F, 7'd127, 1'b0, 1'b1, 1'b1, 1'b1);
      // open literal, closed by a new statement
      add_text("'k");
      send_card(99, 1'b0, 1'b0, 1'b1);
      push_char(7'h00, 7'd0, 1'b1, 1'b0, 1'b1, 1'b0);
      push_char(CH_SPACE, 7'd64, 1'b0, 1'b0, 1'b1, 1'b0);
      push_char(7'h7F, 7'd127, 1'b0, 1'b1, 1'b1, 1'b0);
      wait_for_results();

      // random statements over four idle/stall phases
      base  = counted;
      phase = 0;
      while (counted - base < RANDOM_ITEMS) begin
         if ((counted - base) * 4 / RANDOM_ITEMS != phase) begin
            phase = (counted - base) * 4 / RANDOM_ITEMS;
            wait_for_results();
            case (phase)
               1: begin send_gap_pct = 45; sink_stall_pct = 0;  end
               2: begin send_gap_pct = 0;  sink_stall_pct = 45; end
               default: begin send_gap_pct = 7; sink_stall_pct = 7; end
            endcase
         end
         if ($urandom_range(19) == 0) begin
            repeat ($urandom_range(1, 3))
               push_char(7'($urandom_range(127)), 7'($urandom_range(127)),
                         1'($urandom_range(1)), 1'($urandom_range(1)),
                         1'($urandom_range(1)), 1'($urandom_range(1)));
         end else begin
            is_data = ($urandom_range(3) == 0);
            if (is_data) add_text($urandom_range(1) ? "data" : "DATA");
            repeat ($urandom_range(2, 8)) add_token(is_data);
            first = 1'b1;
            while (text_q.size() != 0) begin
               send_card($urandom_range(1, 10), first, 1'($urandom_range(11) == 0),
                         $urandom_range(15) != 0);
               first = 1'b0;
            end
         end
      end

      // saturated hollerith count, after using up any count still running
      wait_for_results();
      send_gap_pct   = 7;
      sink_stall_pct = 7;
      send_filler(int'(verbatim_left));
      add_text("=99999h");
      send_card(99, 1'b1, 1'b0, 1'b1);
      send_filler(SAT_FILLER);

      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("sent %0d characters on %0d cards, checked %0d result beats (%0d comment)",
               chars_sent, cards_sent, beats_checked, comment_beats);
      $display("literals, hollerith counts up to saturation, comments and label-bang cards");
      $display("with sender idling and receiver stalling phases");
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/fsc_pkg.sv
hdl/fixed_form_statement_cruncher.sv
tb/fsc_result_checker.sv
tb/fixed_form_statement_cruncher_tb.sv
